[design/jmhp_pkg.sv]
// shared types, codes and constants of the jpeg marker header parser
package jmhp_pkg;

    // default depth of the command queue between the parser and the result stage
    localparam int DEF_QUEUE_DEPTH = 4;

    // parser phases
    typedef enum logic [4:0] {
        PH_FIRST,
        PH_SECOND_OK,
        PH_SECOND_BAD,
        PH_FIND_FF,
        PH_MARKER,
        PH_SKIP_HI,
        PH_SKIP_LO,
        PH_SKIP_BODY,
        PH_COM_HI,
        PH_COM_LO,
        PH_COM_BODY,
        PH_SOF_HI,
        PH_SOF_LO,
        PH_SOF_PREC,
        PH_SOF_HH,
        PH_SOF_HL,
        PH_SOF_WH,
        PH_SOF_WL,
        PH_SOF_NC,
        PH_SOF_COMPS,
        PH_DONE,
        PH_STOPPED
    } phase_t;

    // result kinds
    typedef enum logic [2:0] {
        K_TEXT    = 3'd0,
        K_FRAME   = 3'd1,
        K_APP12   = 3'd2,
        K_END     = 3'd3,
        K_ERROR   = 3'd4,
        K_GARBAGE = 3'd5
    } kind_t;

    // error codes
    typedef enum logic [1:0] {
        ERR_NOT_JPEG  = 2'd0,
        ERR_EARLY_EOF = 2'd1,
        ERR_SHORT_LEN = 2'd2,
        ERR_SOF_LEN   = 2'd3
    } err_t;

    // how one comment byte turns into characters
    typedef enum logic [2:0] {
        TX_NONE,
        TX_CHAR,
        TX_NEWLINE,
        TX_BSLASH2,
        TX_OCTAL
    } txt_t;

    // configuration register indexes
    localparam logic REG_VERBOSE = 1'b0;
    localparam logic REG_RAW     = 1'b1;

    // marker and character codes
    localparam logic [7:0] BYTE_FF     = 8'hFF;
    localparam logic [7:0] MK_SOI      = 8'hD8;
    localparam logic [7:0] MK_SOS      = 8'hDA;
    localparam logic [7:0] MK_EOI      = 8'hD9;
    localparam logic [7:0] MK_COM      = 8'hFE;
    localparam logic [7:0] MK_APP12    = 8'hEC;
    localparam logic [3:0] SOF_NIBBLE  = 4'hC;
    localparam logic [3:0] NIB_DHT     = 4'h4;
    localparam logic [3:0] NIB_JPG     = 4'h8;
    localparam logic [3:0] NIB_DAC     = 4'hC;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] PRINT_LO    = 8'h20;
    localparam logic [7:0] PRINT_HI    = 8'h7E;
    localparam logic [15:0] MIN_SEG_LEN   = 16'd2;
    localparam logic [15:0] SOF_FIXED_LEN = 16'd8;

    typedef struct packed {
        logic verbose;
        logic raw_text;
    } cfg_t;

    // everything one input byte asks the result stage to emit, in emit order
    typedef struct packed {
        logic        garbage;
        logic        has_end;
        logic        end_eoi;
        logic        has_app12;
        logic        has_frame;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  comps;
        logic [7:0]  prec;
        logic [3:0]  sof_idx;
        logic        has_err;
        err_t        err_code;
        txt_t        txt;
        logic [7:0]  txt_byte;
        logic        tail_nl;
    } cmd_t;

    // one result item
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  text_char;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  comps;
        logic [7:0]  prec;
        logic [3:0]  sof_idx;
        logic        end_marker;
        err_t        err;
        logic        last;
    } res_t;

    // true while a command still has results to emit
    function automatic logic cmd_pending(cmd_t c);
        return c.garbage | c.has_end | c.has_app12 | c.has_frame | c.has_err |
               (c.txt != TX_NONE) | c.tail_nl;
    endfunction

endpackage

[design/jmhp_front.sv]
// byte parser: walks the marker structure and issues at most one command per byte
module jmhp_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  jmhp_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      data_byte,
    input  logic            end_of_file,
    input  logic            new_file,
    input  logic            q_full,
    output logic            push,
    output jmhp_pkg::cmd_t  push_cmd
);
    import jmhp_pkg::*;

    phase_t      phase_reg, phase_next, ph;
    logic [15:0] seg_reg, seg_next, seg;
    logic [9:0]  cbl_reg, cbl_next, cbl;
    logic [15:0] slen_reg, slen_next, slen;
    logic [7:0]  sprec_reg, sprec_next, sprec;
    logic [15:0] sh_reg, sh_next, sh;
    logic [15:0] sw_reg, sw_next, sw;
    logic [3:0]  sidx_reg, sidx_next, sidx;
    logic [7:0]  prev_reg, prev_next, prev;
    logic        garb_reg, garb_next, garb;
    logic        accept;
    logic [15:0] len;
    logic [9:0]  nc3;
    logic [3:0]  nib;
    cmd_t        cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && cmd_pending(cmd);
    assign push_cmd = cmd;

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            seg_reg   <= '0;
            cbl_reg   <= '0;
            slen_reg  <= '0;
            sprec_reg <= '0;
            sh_reg    <= '0;
            sw_reg    <= '0;
            sidx_reg  <= '0;
            prev_reg  <= '0;
            garb_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            seg_reg   <= seg_next;
            cbl_reg   <= cbl_next;
            slen_reg  <= slen_next;
            sprec_reg <= sprec_next;
            sh_reg    <= sh_next;
            sw_reg    <= sw_next;
            sidx_reg  <= sidx_next;
            prev_reg  <= prev_next;
            garb_reg  <= garb_next;
        end
    end

    // a new file starts from a cleared parse
    always_comb begin
        ph    = new_file ? PH_FIRST : phase_reg;
        seg   = new_file ? '0 : seg_reg;
        cbl   = new_file ? '0 : cbl_reg;
        slen  = new_file ? '0 : slen_reg;
        sprec = new_file ? '0 : sprec_reg;
        sh    = new_file ? '0 : sh_reg;
        sw    = new_file ? '0 : sw_reg;
        sidx  = new_file ? '0 : sidx_reg;
        prev  = new_file ? '0 : prev_reg;
        garb  = new_file ? 1'b0 : garb_reg;
    end

    assign len = {seg[15:8], data_byte};
    assign nc3 = {1'b0, data_byte, 1'b0} + {2'b00, data_byte};
    assign nib = data_byte[3:0];

    // next state and command
    always_comb begin
        phase_next = ph;
        seg_next   = seg;
        cbl_next   = cbl;
        slen_next  = slen;
        sprec_next = sprec;
        sh_next    = sh;
        sw_next    = sw;
        sidx_next  = sidx;
        prev_next  = prev;
        garb_next  = garb;
        cmd        = '0;
        if (end_of_file) begin
            if (ph == PH_FIRST || ph == PH_SECOND_OK || ph == PH_SECOND_BAD) begin
                cmd.has_err  = 1'b1;
                cmd.err_code = ERR_NOT_JPEG;
                phase_next   = PH_STOPPED;
            end else if (ph != PH_DONE && ph != PH_STOPPED) begin
                cmd.has_err  = 1'b1;
                cmd.err_code = ERR_EARLY_EOF;
                phase_next   = PH_STOPPED;
            end
        end else begin
            unique case (ph)
                PH_FIRST: begin
                    phase_next = (data_byte == BYTE_FF) ? PH_SECOND_OK : PH_SECOND_BAD;
                end
                PH_SECOND_OK: begin
                    if (data_byte == MK_SOI) begin
                        phase_next = PH_FIND_FF;
                    end else begin
                        cmd.has_err  = 1'b1;
                        cmd.err_code = ERR_NOT_JPEG;
                        phase_next   = PH_STOPPED;
                    end
                end
                PH_SECOND_BAD: begin
                    cmd.has_err  = 1'b1;
                    cmd.err_code = ERR_NOT_JPEG;
                    phase_next   = PH_STOPPED;
                end
                PH_FIND_FF: begin
                    if (data_byte == BYTE_FF) begin
                        phase_next = PH_MARKER;
                    end else begin
                        garb_next = 1'b1;
                    end
                end
                PH_MARKER: begin
                    if (data_byte != BYTE_FF) begin
                        if (garb) begin
                            cmd.garbage = 1'b1;
                            garb_next   = 1'b0;
                        end
                        // marker dispatch
                        if (data_byte[7:4] == SOF_NIBBLE && nib != NIB_DHT &&
                            nib != NIB_JPG && nib != NIB_DAC) begin
                            if (cfg.verbose) begin
                                sidx_next  = nib - {3'b000, (nib > NIB_DHT)}
                                                 - {3'b000, (nib > NIB_JPG)}
                                                 - {3'b000, (nib > NIB_DAC)};
                                phase_next = PH_SOF_HI;
                            end else begin
                                phase_next = PH_SKIP_HI;
                            end
                        end else if (data_byte == MK_SOS || data_byte == MK_EOI) begin
                            cmd.has_end = 1'b1;
                            cmd.end_eoi = (data_byte == MK_EOI);
                            phase_next  = PH_DONE;
                        end else if (data_byte == MK_COM) begin
                            phase_next = PH_COM_HI;
                        end else if (data_byte == MK_APP12 && cfg.verbose) begin
                            cmd.has_app12 = 1'b1;
                            phase_next    = PH_COM_HI;
                        end else begin
                            phase_next = PH_SKIP_HI;
                        end
                    end
                end
                PH_SKIP_HI: begin
                    seg_next   = {data_byte, 8'h00};
                    phase_next = PH_SKIP_LO;
                end
                PH_COM_HI: begin
                    seg_next   = {data_byte, 8'h00};
                    phase_next = PH_COM_LO;
                end
                PH_SKIP_LO: begin
                    if (len < MIN_SEG_LEN) begin
                        cmd.has_err  = 1'b1;
                        cmd.err_code = ERR_SHORT_LEN;
                        phase_next   = PH_STOPPED;
                    end else begin
                        seg_next   = len - MIN_SEG_LEN;
                        phase_next = (len != MIN_SEG_LEN) ? PH_SKIP_BODY : PH_FIND_FF;
                    end
                end
                PH_SKIP_BODY: begin
                    seg_next = seg - 16'd1;
                    if (seg == 16'd1) begin
                        phase_next = PH_FIND_FF;
                    end
                end
                PH_COM_LO: begin
                    if (len < MIN_SEG_LEN) begin
                        cmd.has_err  = 1'b1;
                        cmd.err_code = ERR_SHORT_LEN;
                        phase_next   = PH_STOPPED;
                    end else begin
                        seg_next  = len - MIN_SEG_LEN;
                        prev_next = '0;
                        if (len == MIN_SEG_LEN) begin
                            cmd.tail_nl = 1'b1;
                            phase_next  = PH_FIND_FF;
                        end else begin
                            phase_next = PH_COM_BODY;
                        end
                    end
                end
                PH_COM_BODY: begin
                    // escape class of the comment byte
                    cmd.txt_byte = data_byte;
                    if (cfg.raw_text) begin
                        cmd.txt = TX_CHAR;
                    end else if (data_byte == CHAR_CR) begin
                        cmd.txt = TX_NEWLINE;
                    end else if (data_byte == CHAR_LF) begin
                        cmd.txt = (prev != CHAR_CR) ? TX_NEWLINE : TX_NONE;
                    end else if (data_byte == CHAR_BSLASH) begin
                        cmd.txt = TX_BSLASH2;
                    end else if (data_byte >= PRINT_LO && data_byte <= PRINT_HI) begin
                        cmd.txt = TX_CHAR;
                    end else begin
                        cmd.txt = TX_OCTAL;
                    end
                    prev_next = data_byte;
                    seg_next  = seg - 16'd1;
                    if (seg == 16'd1) begin
                        cmd.tail_nl = 1'b1;
                        phase_next  = PH_FIND_FF;
                    end
                end
                PH_SOF_HI: begin
                    slen_next  = {data_byte, 8'h00};
                    phase_next = PH_SOF_LO;
                end
                PH_SOF_LO: begin
                    slen_next  = {slen[15:8], data_byte};
                    phase_next = PH_SOF_PREC;
                end
                PH_SOF_PREC: begin
                    sprec_next = data_byte;
                    phase_next = PH_SOF_HH;
                end
                PH_SOF_HH: begin
                    sh_next    = {data_byte, 8'h00};
                    phase_next = PH_SOF_HL;
                end
                PH_SOF_HL: begin
                    sh_next    = {sh[15:8], data_byte};
                    phase_next = PH_SOF_WH;
                end
                PH_SOF_WH: begin
                    sw_next    = {data_byte, 8'h00};
                    phase_next = PH_SOF_WL;
                end
                PH_SOF_WL: begin
                    sw_next    = {sw[15:8], data_byte};
                    phase_next = PH_SOF_NC;
                end
                PH_SOF_NC: begin
                    cmd.has_frame = 1'b1;
                    cmd.width     = sw;
                    cmd.height    = sh;
                    cmd.comps     = data_byte;
                    cmd.prec      = sprec;
                    cmd.sof_idx   = sidx;
                    // segment length must cover the component table exactly
                    if (slen != SOF_FIXED_LEN + {6'b000000, nc3}) begin
                        cmd.has_err  = 1'b1;
                        cmd.err_code = ERR_SOF_LEN;
                        phase_next   = PH_STOPPED;
                    end else begin
                        cbl_next   = nc3;
                        phase_next = (nc3 != '0) ? PH_SOF_COMPS : PH_FIND_FF;
                    end
                end
                PH_SOF_COMPS: begin
                    cbl_next = cbl - 10'd1;
                    if (cbl == 10'd1) begin
                        phase_next = PH_FIND_FF;
                    end
                end
                PH_DONE, PH_STOPPED: begin
                    phase_next = ph;
                end
                default: begin
                    phase_next = PH_STOPPED;
                end
            endcase
        end
    end

endmodule

[design/jmhp_cmd_queue.sv]
// small command queue between the parser and the result stage
module jmhp_cmd_queue #(
    parameter int DEPTH = jmhp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  jmhp_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output jmhp_pkg::cmd_t  q_cmd
);
    import jmhp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

endmodule

[design/jmhp_back.sv]
// result stage: expands each command into result items, one per cycle while the output is not stalled
module jmhp_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  jmhp_pkg::cmd_t  q_cmd,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output jmhp_pkg::res_t  out_res
);
    import jmhp_pkg::*;

    cmd_t       cur_reg, rem;
    logic       cur_valid_reg;
    logic [1:0] step_reg, step_next;
    logic       out_valid_reg;
    res_t       out_reg, item;
    logic [7:0] tchar;
    logic       txt_done;
    logic       out_free, emit, cur_done;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = cur_valid_reg && out_free;
    assign cur_done  = emit && item.last;
    assign pop       = q_valid && (!cur_valid_reg || cur_done);
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    // character of the current escape step
    always_comb begin
        tchar    = cur_reg.txt_byte;
        txt_done = 1'b1;
        case (cur_reg.txt)
            TX_NEWLINE: tchar = CHAR_LF;
            TX_BSLASH2: begin
                tchar    = CHAR_BSLASH;
                txt_done = (step_reg == 2'd1);
            end
            TX_OCTAL: begin
                txt_done = (step_reg == 2'd3);
                case (step_reg)
                    2'd0:    tchar = CHAR_BSLASH;
                    2'd1:    tchar = CHAR_ZERO + {6'b000000, cur_reg.txt_byte[7:6]};
                    2'd2:    tchar = CHAR_ZERO + {5'b00000, cur_reg.txt_byte[5:3]};
                    default: tchar = CHAR_ZERO + {5'b00000, cur_reg.txt_byte[2:0]};
                endcase
            end
            default: tchar = cur_reg.txt_byte;
        endcase
    end

    // pick the next result in emit order
    always_comb begin
        item      = '0;
        rem       = cur_reg;
        step_next = step_reg;
        if (cur_reg.garbage) begin
            item.kind   = K_GARBAGE;
            rem.garbage = 1'b0;
        end else if (cur_reg.has_end) begin
            item.kind       = K_END;
            item.end_marker = cur_reg.end_eoi;
            rem.has_end     = 1'b0;
        end else if (cur_reg.has_app12) begin
            item.kind     = K_APP12;
            rem.has_app12 = 1'b0;
        end else if (cur_reg.has_frame) begin
            item.kind     = K_FRAME;
            item.width    = cur_reg.width;
            item.height   = cur_reg.height;
            item.comps    = cur_reg.comps;
            item.prec     = cur_reg.prec;
            item.sof_idx  = cur_reg.sof_idx;
            rem.has_frame = 1'b0;
        end else if (cur_reg.has_err) begin
            item.kind   = K_ERROR;
            item.err    = cur_reg.err_code;
            rem.has_err = 1'b0;
        end else if (cur_reg.txt != TX_NONE) begin
            item.kind      = K_TEXT;
            item.text_char = tchar;
            if (txt_done) begin
                rem.txt   = TX_NONE;
                step_next = 2'd0;
            end else begin
                step_next = step_reg + 2'd1;
            end
        end else if (cur_reg.tail_nl) begin
            item.kind      = K_TEXT;
            item.text_char = CHAR_LF;
            rem.tail_nl    = 1'b0;
        end
        item.last = !cmd_pending(rem);
    end

    // current command
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
        end else if (pop) begin
            cur_valid_reg <= 1'b1;
            step_reg      <= 2'd0;
        end else if (cur_done) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
        end else if (emit) begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= q_cmd;
        end else if (emit) begin
            cur_reg <= rem;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= item;
        end
    end

endmodule

[design/jpeg_marker_header_parser.sv]
// jpeg marker header parser: signature check, marker walk, frame info and comment text
// path: a result's command passes through the command queue, the current command register and the output register
// throughput: one byte per cycle while the command queue has room; results leave
// at one per cycle while m_ready is high, so an octal-escaped comment byte (up to
// 5 results) holds the result stage and back-pressures the input through the queue
// reset: synchronous active-low aresetn clears the parse, the queue and both config bits
module jpeg_marker_header_parser #(
    parameter int QUEUE_DEPTH = jmhp_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic        cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_file,
    input  logic        s_new_file,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_kind,
    output logic [7:0]  m_text_char,
    output logic [15:0] m_frame_width,
    output logic [15:0] m_frame_height,
    output logic [7:0]  m_component_count,
    output logic [7:0]  m_sample_precision,
    output logic [3:0]  m_sof_process,
    output logic        m_end_marker,
    output logic [1:0]  m_error_code,
    output logic        m_last
);
    import jmhp_pkg::*;

    cfg_t cfg_reg;
    logic push, full, pop, q_valid;
    cmd_t push_cmd, q_cmd;
    res_t res;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_VERBOSE) begin
                cfg_reg.verbose <= cfg_wr_data;
            end else begin
                cfg_reg.raw_text <= cfg_wr_data;
            end
        end
    end

    jmhp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .data_byte   (s_data_byte),
        .end_of_file (s_end_of_file),
        .new_file    (s_new_file),
        .q_full      (full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    jmhp_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    jmhp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res)
    );

    // result fields
    assign m_out_kind         = res.kind;
    assign m_text_char        = res.text_char;
    assign m_frame_width      = res.width;
    assign m_frame_height     = res.height;
    assign m_component_count  = res.comps;
    assign m_sample_precision = res.prec;
    assign m_sof_process      = res.sof_idx;
    assign m_end_marker       = res.end_marker;
    assign m_error_code       = res.err;
    assign m_last             = res.last;

endmodule

[design/jmhp_checker.sv]
// port-level checks of the jpeg marker header parser and their binding
module jmhp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_out_kind,
    input logic [7:0]  m_text_char,
    input logic [15:0] m_frame_width,
    input logic [15:0] m_frame_height,
    input logic [7:0]  m_component_count,
    input logic [7:0]  m_sample_precision,
    input logic [3:0]  m_sof_process,
    input logic        m_last
);
    import jmhp_pkg::*;

    // no result in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_kind) &&
            $stable(m_text_char) && $stable(m_last))
        else $error("stalled result changed");

    // errors and header ends close the results of their byte
    a_final_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_out_kind == K_ERROR || m_out_kind == K_END) |-> m_last)
        else $error("error or header end not marked last");

    // frame fields are zero outside frame info
    a_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind != K_FRAME |->
            m_frame_width == '0 && m_frame_height == '0 &&
            m_component_count == '0 && m_sample_precision == '0 && m_sof_process == '0)
        else $error("frame fields set on a non-frame result");

    // text char only on text results
    a_text_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind != K_TEXT |-> m_text_char == '0)
        else $error("text char set on a non-text result");

endmodule

bind jpeg_marker_header_parser jmhp_checker u_jmhp_checker (.*);
